>>> src/pfk_pkg.sv
// Shared types, widths and table helpers for the planar chain kinematics block.
package pfk_pkg;

	localparam int ANGLE_W   = 16;
	localparam int POS_W     = 24;
	localparam int FRAC_W    = 16;
	localparam int TBL_W     = 10;
	localparam int QTR_W     = TBL_W - 2;
	localparam int QTR       = 1 << QTR_W;
	localparam int QVAL_W    = FRAC_W + 1;
	localparam int TRIG_W    = FRAC_W + 2;
	localparam int MAX_LINKS = 2;
	localparam int LINK_W    = $clog2(MAX_LINKS + 1);

	localparam real PI       = 3.14159265358979323846;
	localparam real STEP_RAD = 2.0 * PI / real'(1 << TBL_W);

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    last;
	} point_t;

	// Quarter-wave cosine sample, Q.16, evaluated at elaboration only.
	function automatic int quarter_cos(input int k);
		real a;
		a = STEP_RAD * real'(k);
		return $rtoi($floor(real'(1 << FRAC_W) * $cos(a) + 0.5));
	endfunction

endpackage

>>> src/pfk_trig.sv
// Cosine and sine lookup from a quarter-wave table, indexed by top heading bits.
module pfk_trig (
	input  logic [pfk_pkg::TBL_W-1:0] index,
	output pfk_pkg::trig_t            trig
);

	logic [pfk_pkg::QVAL_W-1:0] qcos [pfk_pkg::QTR+1];

	for (genvar k = 0; k <= pfk_pkg::QTR; k++) begin : g_tab
		localparam int QV = pfk_pkg::quarter_cos(k);
		assign qcos[k] = pfk_pkg::QVAL_W'(QV);
	end

	logic signed [pfk_pkg::TRIG_W-1:0] lane_v [2];

	// Lane 0 is cosine; lane 1 is sine, read a quarter turn back.
	always_comb begin
		logic [pfk_pkg::TBL_W-1:0]  lane_idx;
		logic [1:0]                 quad;
		logic [pfk_pkg::QTR_W:0]    low;
		logic [pfk_pkg::QTR_W:0]    mirror;
		logic [pfk_pkg::QVAL_W-1:0] mag;
		logic signed [pfk_pkg::TRIG_W-1:0] pos_v;
		for (int l = 0; l < 2; l++) begin
			lane_idx = (l == 0) ? index : index - pfk_pkg::TBL_W'(pfk_pkg::QTR);
			quad     = lane_idx[pfk_pkg::TBL_W-1 -: 2];
			low      = {1'b0, lane_idx[pfk_pkg::QTR_W-1:0]};
			mirror   = (pfk_pkg::QTR_W+1)'(pfk_pkg::QTR) - low;
			mag      = quad[0] ? qcos[mirror] : qcos[low];
			pos_v    = signed'({1'b0, mag});
			lane_v[l] = (quad[0] ^ quad[1]) ? -pos_v : pos_v;
		end
	end

	assign trig.cos_v = lane_v[0];
	assign trig.sin_v = lane_v[1];

endmodule

>>> src/pfk_chain.sv
// Running heading, position sums and link count of the current chain.
module pfk_chain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [pfk_pkg::ANGLE_W-1:0]  joint_angle,
	input  logic                                last_link,
	output pfk_pkg::point_t                     nxt
);

	logic [pfk_pkg::ANGLE_W-1:0]      heading_q;
	logic signed [pfk_pkg::POS_W-1:0] sum_x_q;
	logic signed [pfk_pkg::POS_W-1:0] sum_y_q;
	logic [pfk_pkg::LINK_W-1:0]       count_q;

	logic [pfk_pkg::ANGLE_W-1:0] heading_d;
	logic [pfk_pkg::LINK_W-1:0]  count_d;
	pfk_pkg::trig_t              trig;

	assign heading_d = heading_q + pfk_pkg::ANGLE_W'(unsigned'(joint_angle));
	assign count_d   = count_q + pfk_pkg::LINK_W'(1);

	pfk_trig u_trig (
		.index (heading_d[pfk_pkg::ANGLE_W-1 -: pfk_pkg::TBL_W]),
		.trig  (trig)
	);

	assign nxt.x    = sum_x_q + pfk_pkg::POS_W'(trig.cos_v);
	assign nxt.y    = sum_y_q + pfk_pkg::POS_W'(trig.sin_v);
	assign nxt.last = last_link || (count_d >= pfk_pkg::LINK_W'(pfk_pkg::MAX_LINKS));

	// Advance on each point; clear everything once the chain ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			count_q   <= '0;
		end else if (en) begin
			if (nxt.last) begin
				heading_q <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				count_q   <= '0;
			end else begin
				heading_q <= heading_d;
				sum_x_q   <= nxt.x;
				sum_y_q   <= nxt.y;
				count_q   <= count_d;
			end
		end
	end

	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		en && nxt.last |=> heading_q == '0 && sum_x_q == '0 && sum_y_q == '0
			&& count_q == '0)
		else $error("chain state not cleared after end point");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) < pfk_pkg::MAX_LINKS)
		else $error("link count reached limit without clearing");

	a_force_end: assert property (@(posedge clk) disable iff (!arst_n)
		en && int'(count_q) == pfk_pkg::MAX_LINKS - 1 |-> nxt.last)
		else $error("overlong chain not terminated");

endmodule

>>> src/planar_chain_forward_kinematics.sv
// Top level: planar serial-chain forward kinematics with unit links.
//
// Usage:
//  - Input channel (in_valid / in_stall, joint_angle, last_link): one relative
//    joint angle per transfer, 65536 units per turn. last_link ends the chain.
//  - Output channel (out_valid / out_stall, pos_x, pos_y, last_point): one
//    joint point in Q.16 per input transfer, in order.
//  - A chain also ends on its MAX_LINKS-th link; last_point marks the end and
//    heading and position then restart from zero.
//  - The angle passes through the input register, then the result register,
//    where out_valid rises and the point waits for transfer. Throughput: one
//    item per cycle while out_stall is low, set by the heading add, table
//    lookup and position add that close the state loop combinationally.
//  - Receiver stall: the result register holds; the input register fills,
//    then in_stall rises. in_stall follows out_stall combinationally.
//  - Reset (arst_n low): both pipeline stages empty, heading and position
//    cleared; nothing is held in flight.
module planar_chain_forward_kinematics (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [pfk_pkg::ANGLE_W-1:0] joint_angle,
	input  logic                               last_link,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pfk_pkg::POS_W-1:0]   pos_x,
	output logic signed [pfk_pkg::POS_W-1:0]   pos_y,
	output logic                               last_point
);

	// Stage 1: captured input item.
	logic                               valid_s1;
	logic signed [pfk_pkg::ANGLE_W-1:0] angle_s1;
	logic                               last_s1;

	// Stage 2: finished point waiting for transfer.
	logic            valid_s2;
	pfk_pkg::point_t point_s2;

	logic            s2_free;
	logic            s1_free;
	logic            advance;
	pfk_pkg::point_t nxt;

	// A stage frees up when empty or when its content leaves this cycle.
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_free  = !valid_s1 || s2_free;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers: load on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			angle_s1 <= joint_angle;
			last_s1  <= last_link;
		end
		if (advance) begin
			point_s2 <= nxt;
		end
	end

	// The chain state moves exactly when a point enters the result register.
	pfk_chain u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.joint_angle (angle_s1),
		.last_link   (last_s1),
		.nxt         (nxt)
	);

	assign out_valid  = valid_s2;
	assign pos_x      = point_s2.x;
	assign pos_y      = point_s2.y;
	assign last_point = point_s2.last;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item missing from result register");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_stall && !valid_s1 |=> !valid_s2)
		else $error("result register kept a transferred point");

endmodule
